@@ hdl/ares_pkg.sv @@
// Shared types, constants and arithmetic helpers for the angle and rate estimator.
`default_nettype none

package ares_pkg;

  // Field widths
  localparam int COUNT_W   = 21;
  localparam int CENTER_W  = 13;
  localparam int HEADING_W = 24;
  localparam int ANGLE_W   = 26;
  localparam int RATE_W    = 30;
  localparam int TARGET_W  = ANGLE_W + 1;

  // Window and encoder geometry
  localparam int WINDOW_LEN      = 10;
  localparam int HALF_LEN        = WINDOW_LEN / 2;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int CPT_LOG2        = $clog2(COUNTS_PER_TURN);

  // Count to Q8 degrees: angle = (diff * 360 * 256 + CPT/2) >>> log2(CPT)
  localparam int DEG_SCALE = 360 * 256;
  localparam int DIFF_W    = COUNT_W + 1;
  localparam int PROD_W    = DIFF_W + $clog2(DEG_SCALE) + 1;
  localparam int SAT_W     = PROD_W;
  localparam logic signed [PROD_W-1:0] DEG_SCALE_K = PROD_W'(DEG_SCALE);
  localparam logic signed [PROD_W-1:0] HALF_TURN_K = PROD_W'(COUNTS_PER_TURN / 2);

  // Saturation limits
  localparam logic signed [SAT_W-1:0] ANGLE_MAX_K = SAT_W'(2**(ANGLE_W-1) - 1);
  localparam logic signed [SAT_W-1:0] ANGLE_MIN_K = -(SAT_W'(2**(ANGLE_W-1)));
  localparam logic signed [SAT_W-1:0] RATE_MAX_K  = SAT_W'(2**(RATE_W-1) - 1);
  localparam logic signed [SAT_W-1:0] RATE_MIN_K  = -(SAT_W'(2**(RATE_W-1)));

  // Smoothing filter: floor(w / 5) by reciprocal, w biased to stay positive
  localparam int          FILT_NUM_W  = 31;
  localparam int          FILT_BIAS   = 2**28;
  localparam int          FILT_OFFSET = 5 * FILT_BIAS;
  localparam logic [31:0] FILT_RECIP  = 32'hCCCC_CCCD;
  localparam int          FILT_SHIFT  = 34;
  localparam int          FILT_Q_W    = 64 - FILT_SHIFT;

  // Slope: floor(acc / 33) by reciprocal, acc biased by 33 * 2^26
  localparam int          ACC_W        = 32;
  localparam int          SLOPE_BIAS   = 2**26;
  localparam logic [32:0] SLOPE_OFFSET = 33'd2214592512;
  localparam logic [31:0] SLOPE_RECIP  = 32'hF83E_0F84;
  localparam int          SLOPE_SHIFT  = 37;
  localparam int          SLOPE_Q_W    = 64 - SLOPE_SHIFT;
  localparam int          REM_W        = 6;
  localparam int          SLOPE_DIV    = 33;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PITCH_CENTER = 2'd0;
  localparam logic [1:0] REG_YAW_CENTER   = 2'd1;
  localparam logic [1:0] REG_HEADING_NEG  = 2'd2;

  typedef logic signed [COUNT_W-1:0]   count_t;
  typedef logic        [CENTER_W-1:0]  center_t;
  typedef logic signed [HEADING_W-1:0] heading_t;
  typedef logic signed [ANGLE_W-1:0]   angle_t;
  typedef logic signed [TARGET_W-1:0]  target_t;
  typedef logic signed [RATE_W-1:0]    rate_t;
  typedef angle_t [WINDOW_LEN-1:0]     window_t;

  typedef struct packed {
    center_t pitch_center;
    center_t yaw_center;
    logic    heading_negate;
  } cfg_t;

  function automatic angle_t sat_angle(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    if (v > ANGLE_MAX_K) c = ANGLE_MAX_K;
    else if (v < ANGLE_MIN_K) c = ANGLE_MIN_K;
    else c = v;
    return c[ANGLE_W-1:0];
  endfunction

  function automatic rate_t sat_rate(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    if (v > RATE_MAX_K) c = RATE_MAX_K;
    else if (v < RATE_MIN_K) c = RATE_MIN_K;
    else c = v;
    return c[RATE_W-1:0];
  endfunction

  // Encoder count relative to center, scaled to Q8 degrees, rounded half up
  function automatic angle_t count_to_angle(input count_t count, input center_t center);
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    diff = DIFF_W'(count) - $signed({1'b0, center});
    prod = PROD_W'(diff) * DEG_SCALE_K + HALF_TURN_K;
    return sat_angle(SAT_W'(prod >>> CPT_LOG2));
  endfunction

  // floor((10 * r + 16) / 33) for a remainder r below 33
  function automatic logic [3:0] frac_round(input logic [REM_W-1:0] r);
    logic [9:0] n;
    logic [3:0] c;
    n = 10'(r) * 10'd10 + 10'd16;
    c = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= 10'(SLOPE_DIV * k)) c = c + 4'd1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ares_angle.sv @@
// Stage that turns encoder counts into angles and forms the yaw target.
`default_nettype none

module ares_angle import ares_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  cfg_t     cfg,
  input  wire      in_valid,
  output logic     in_ready,
  input  count_t   pitch_count,
  input  count_t   yaw_count,
  input  heading_t heading,
  output logic     out_valid,
  input  wire      out_ready,
  output angle_t   pitch_angle,
  output target_t  target
);

  angle_t  p_ang;
  angle_t  y_ang;
  target_t hd;
  target_t tgt;

  // Convert both counts and add the (optionally negated) heading
  always_comb begin
    p_ang = count_to_angle(pitch_count, cfg.pitch_center);
    y_ang = count_to_angle(yaw_count, cfg.yaw_center);
    hd    = cfg.heading_negate ? -(TARGET_W'(heading)) : TARGET_W'(heading);
    tgt   = hd + TARGET_W'(y_ang);
  end

  assign in_ready = !out_valid || out_ready;

  // Hold the beat until the next stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pitch_angle <= p_ang;
      target      <= tgt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ares_filter.sv @@
// Yaw smoothing filter and the two sample windows.
`default_nettype none

module ares_filter import ares_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  angle_t  pitch_angle,
  input  target_t target,
  output logic    out_valid,
  input  wire     out_ready,
  output window_t pitch_win,
  output window_t yaw_win
);

  localparam int LAST = WINDOW_LEN - 1;

  logic                         load;
  logic signed [FILT_NUM_W-1:0] ys_x;
  logic signed [FILT_NUM_W-1:0] t_x;
  logic signed [FILT_NUM_W-1:0] num;
  logic signed [FILT_NUM_W-1:0] w;
  logic signed [32:0]           wb;
  logic        [31:0]           u;
  logic        [63:0]           prod;
  logic        [FILT_Q_W-1:0]   q;
  logic signed [31:0]           qs;
  angle_t                       ys_next;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // ys_next = floor((7 * ys + 3 * t + 5) / 10); newest yaw sample is the filter state
  always_comb begin
    ys_x    = FILT_NUM_W'($signed(yaw_win[LAST]));
    t_x     = FILT_NUM_W'(target);
    num     = (ys_x <<< 3) - ys_x + (t_x <<< 1) + t_x;
    w       = (num + FILT_NUM_W'(5)) >>> 1;
    wb      = 33'(w) + 33'(FILT_OFFSET);
    u       = wb[31:0];
    prod    = 64'(u) * 64'(FILT_RECIP);
    q       = prod[63:FILT_SHIFT];
    qs      = $signed({2'b00, q}) - 32'(FILT_BIAS);
    ys_next = sat_angle(SAT_W'(qs));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Shift both windows toward the oldest slot and drop the newest sample in
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_win <= '0;
      yaw_win   <= '0;
    end else if (load) begin
      for (int i = 0; i < LAST; i++) begin
        pitch_win[i] <= pitch_win[i+1];
        yaw_win[i]   <= yaw_win[i+1];
      end
      pitch_win[LAST] <= pitch_angle;
      yaw_win[LAST]   <= ys_next;
    end
  end

  a_shift: assert property (@(posedge clk) disable iff (rst)
    load |=> pitch_win[LAST-1] == $past(pitch_win[LAST]) &&
             yaw_win[LAST-1] == $past(yaw_win[LAST]))
    else $error("window did not shift on a new sample");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("filter stage lost a beat");

endmodule

`default_nettype wire

@@ hdl/ares_slope.sv @@
// Least-squares slope over both windows: weighted sum, reciprocal divide, rounding.
`default_nettype none

module ares_slope import ares_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  window_t pitch_win,
  input  window_t yaw_win,
  output logic    out_valid,
  input  wire     out_ready,
  output angle_t  pitch_angle,
  output rate_t   pitch_rate,
  output angle_t  yaw_angle,
  output rate_t   yaw_rate
);

  localparam int LAST = WINDOW_LEN - 1;

  // Stage valids: terms, biased sum, quotient
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  window_t                 win [2];
  logic signed [ACC_W-1:0] term_c [2][HALF_LEN];
  logic signed [ACC_W-1:0] term   [2][HALF_LEN];
  logic        [31:0]      u_c    [2];
  logic        [31:0]      u      [2];
  logic        [SLOPE_Q_W-1:0] q_c [2];
  logic        [SLOPE_Q_W-1:0] q   [2];
  logic        [REM_W-1:0] ulow   [2];
  logic        [REM_W-1:0] rem    [2];
  rate_t                   rate_c [2];
  angle_t                  a1 [2];
  angle_t                  a2 [2];
  angle_t                  a3 [2];

  assign win[0] = pitch_win;
  assign win[1] = yaw_win;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Pair symmetric taps: acc = sum (2k+1) * (x[5+k] - x[4-k])
  always_comb begin
    logic signed [ANGLE_W:0] d;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < HALF_LEN; k++) begin
        d = (ANGLE_W+1)'($signed(win[l][HALF_LEN+k])) -
            (ANGLE_W+1)'($signed(win[l][HALF_LEN-1-k]));
        term_c[l][k] = ACC_W'(d) * ACC_W'(2 * k + 1);
      end
    end
  end

  // Sum the terms and bias so the quotient stays positive
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic        [32:0]      ub;
    for (int l = 0; l < 2; l++) begin
      acc = '0;
      for (int k = 0; k < HALF_LEN; k++) begin
        acc = acc + term[l][k];
      end
      ub     = 33'(acc) + SLOPE_OFFSET;
      u_c[l] = ub[31:0];
    end
  end

  // floor(u / 33) by reciprocal multiply
  always_comb begin
    logic [63:0] prod;
    for (int l = 0; l < 2; l++) begin
      prod   = 64'(u[l]) * 64'(SLOPE_RECIP);
      q_c[l] = prod[63:SLOPE_SHIFT];
    end
  end

  // rate = 10 * floor(acc / 33) + floor((10 * rem + 16) / 33)
  always_comb begin
    logic signed [31:0] base;
    logic signed [31:0] r32;
    for (int l = 0; l < 2; l++) begin
      rem[l]    = ulow[l] - (q[l][REM_W-1:0] + {q[l][0], 5'b0});
      base      = 32'($signed({1'b0, q[l]})) - 32'(SLOPE_BIAS);
      r32       = base * 32'sd10 + 32'(frac_round(rem[l]));
      rate_c[l] = sat_rate(SAT_W'(r32));
    end
  end

  // Advance valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (in_valid && rdy1) begin
        term[l] <= term_c[l];
        a1[l]   <= win[l][LAST];
      end
      if (v1 && rdy2) begin
        u[l]  <= u_c[l];
        a2[l] <= a1[l];
      end
      if (v2 && rdy3) begin
        q[l]    <= q_c[l];
        ulow[l] <= u[l][REM_W-1:0];
        a3[l]   <= a2[l];
      end
    end
    if (v3 && rdy4) begin
      pitch_angle <= a3[0];
      pitch_rate  <= rate_c[0];
      yaw_angle   <= a3[1];
      yaw_rate    <= rate_c[1];
    end
  end

  a_rem: assert property (@(posedge clk) disable iff (rst)
    v3 |-> rem[0] < REM_W'(SLOPE_DIV) && rem[1] < REM_W'(SLOPE_DIV))
    else $error("slope remainder out of range");

endmodule

`default_nettype wire

@@ hdl/angle_rate_estimator.sv @@
// Top level: configuration registers, input register and the estimator pipeline.
// Registers in order: input, angle, filter, slope terms, sum, quotient and output.
// Throughput: one beat per cycle; every stage holds one beat and stalls only
// when the stages after it are full; ready passes back combinationally to s_tready.
// Reset: synchronous, active high; clears valids, the windows, the yaw filter
// state and the configuration registers. No clearing pass is needed.
`default_nettype none

module angle_rate_estimator import ares_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  // APB-style configuration port
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Input stream
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [71:0]  s_tdata,  // pitch_encoder_count[20:0], yaw_encoder_count[41:21],
                                 // chassis_heading[65:42], zero pad[71:66]
  // Output stream
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [111:0] m_tdata   // pitch_angle[25:0], pitch_rate[55:26],
                                 // yaw_angle[81:56], yaw_rate[111:82]
);

  cfg_t     cfg;
  logic     cfg_wr;
  logic     in_valid;
  count_t   in_pitch;
  count_t   in_yaw;
  heading_t in_heading;

  logic     ang_ready;
  logic     ang_valid;
  angle_t   ang_pitch;
  target_t  ang_target;

  logic     flt_ready;
  logic     flt_valid;
  window_t  pitch_win;
  window_t  yaw_win;

  logic     slp_ready;
  angle_t   pitch_angle;
  rate_t    pitch_rate;
  angle_t   yaw_angle;
  rate_t    yaw_rate;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PITCH_CENTER: cfg.pitch_center   <= pwdata[CENTER_W-1:0];
        REG_YAW_CENTER:   cfg.yaw_center     <= pwdata[CENTER_W-1:0];
        REG_HEADING_NEG:  cfg.heading_negate <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PITCH_CENTER: prdata = 32'(cfg.pitch_center);
      REG_YAW_CENTER:   prdata = 32'(cfg.yaw_center);
      REG_HEADING_NEG:  prdata = 32'(cfg.heading_negate);
      default:          prdata = '0;
    endcase
  end

  // Input register
  assign s_tready = !in_valid || ang_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pitch   <= s_tdata[20:0];
      in_yaw     <= s_tdata[41:21];
      in_heading <= s_tdata[65:42];
    end
  end

  ares_angle u_angle (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (ang_ready),
    .pitch_count (in_pitch),
    .yaw_count   (in_yaw),
    .heading     (in_heading),
    .out_valid   (ang_valid),
    .out_ready   (flt_ready),
    .pitch_angle (ang_pitch),
    .target      (ang_target)
  );

  ares_filter u_filter (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (ang_valid),
    .in_ready    (flt_ready),
    .pitch_angle (ang_pitch),
    .target      (ang_target),
    .out_valid   (flt_valid),
    .out_ready   (slp_ready),
    .pitch_win   (pitch_win),
    .yaw_win     (yaw_win)
  );

  ares_slope u_slope (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (flt_valid),
    .in_ready    (slp_ready),
    .pitch_win   (pitch_win),
    .yaw_win     (yaw_win),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pitch_angle (pitch_angle),
    .pitch_rate  (pitch_rate),
    .yaw_angle   (yaw_angle),
    .yaw_rate    (yaw_rate)
  );

  assign m_tdata = {yaw_rate, yaw_angle, pitch_rate, pitch_angle};

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while the output side was free");

endmodule

`default_nettype wire

@@ test/angle_rate_estimator_tb.sv @@
// Self-checking testbench for the angle and rate estimator: register port and sample stream.
module angle_rate_estimator_tb import ares_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;

  localparam logic [3:0] ADDR_PITCH_CENTER = {REG_PITCH_CENTER, 2'b00};
  localparam logic [3:0] ADDR_YAW_CENTER   = {REG_YAW_CENTER, 2'b00};
  localparam logic [3:0] ADDR_HEADING_NEG  = {REG_HEADING_NEG, 2'b00};
  localparam logic [3:0] ADDR_UNMAPPED     = 4'hC;

  localparam longint ANGLE_HI = (longint'(1) << (ANGLE_W - 1)) - 1;
  localparam longint ANGLE_LO = -(longint'(1) << (ANGLE_W - 1));
  localparam longint RATE_HI  = (longint'(1) << (RATE_W - 1)) - 1;
  localparam longint RATE_LO  = -(longint'(1) << (RATE_W - 1));

  localparam count_t   COUNT_MIN   = {1'b1, {(COUNT_W - 1){1'b0}}};
  localparam count_t   COUNT_MAX   = {1'b0, {(COUNT_W - 1){1'b1}}};
  localparam heading_t HEADING_MIN = {1'b1, {(HEADING_W - 1){1'b0}}};
  localparam heading_t HEADING_MAX = {1'b0, {(HEADING_W - 1){1'b1}}};
  localparam center_t  CENTER_MAX  = '1;

  typedef enum {SEG_NOISE, SEG_RAMP, SEG_HOLD, SEG_CORNER} segment_kind_t;

  typedef struct {
    angle_t pitch_angle;
    rate_t  pitch_rate;
    angle_t yaw_angle;
    rate_t  yaw_rate;
  } estimate_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  wire  [31:0]  prdata;
  wire          pready;
  logic         s_tvalid = 1'b0;
  wire          s_tready;
  logic [71:0]  s_tdata = '0;  // pitch_encoder_count[20:0], yaw_encoder_count[41:21],
                               // chassis_heading[65:42], zero pad[71:66]
  wire          m_tvalid;
  logic         m_tready = 1'b1;
  wire  [111:0] m_tdata;       // pitch_angle[25:0], pitch_rate[55:26],
                               // yaw_angle[81:56], yaw_rate[111:82]

  // Shadow configuration and estimator state
  center_t cfg_pitch_center = '0;
  center_t cfg_yaw_center = '0;
  logic    cfg_heading_negate = 1'b0;
  longint  pitch_hist [WINDOW_LEN] = '{default: 0};
  longint  yaw_hist [WINDOW_LEN] = '{default: 0};
  longint  yaw_filtered = 0;

  estimate_t pending_estimates[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        bursty = 1'b1;
  int        ready_burst_left = 0;

  angle_rate_estimator DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Arithmetic of the estimator, on wide signed integers
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // Round to nearest, ties toward +infinity
  function automatic longint nearest_quot(input longint n, input longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic longint limit_to(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint encoder_degrees(input count_t count, input center_t center);
    longint diff;
    diff = longint'(count) - longint'(center);
    return limit_to(nearest_quot(diff * DEG_SCALE, COUNTS_PER_TURN), ANGLE_LO, ANGLE_HI);
  endfunction

  function automatic longint window_slope(input longint w [WINDOW_LEN]);
    longint acc;
    acc = 0;
    for (int i = 0; i < WINDOW_LEN; i++) acc += longint'(2 * i - (WINDOW_LEN - 1)) * w[i];
    return limit_to(nearest_quot(acc * 10, 33), RATE_LO, RATE_HI);
  endfunction

  // Advance the shadow state by one sample and return the expected beat
  function automatic estimate_t predict_estimate(input count_t pc, input count_t yc,
                                                 input heading_t hd);
    estimate_t est;
    longint    p_ang;
    longint    head;
    longint    tgt;
    p_ang = encoder_degrees(pc, cfg_pitch_center);
    head = cfg_heading_negate ? -longint'(hd) : longint'(hd);
    tgt = head + encoder_degrees(yc, cfg_yaw_center);
    yaw_filtered = limit_to(nearest_quot(7 * yaw_filtered + 3 * tgt, 10), ANGLE_LO, ANGLE_HI);
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      pitch_hist[i] = pitch_hist[i + 1];
      yaw_hist[i] = yaw_hist[i + 1];
    end
    pitch_hist[WINDOW_LEN - 1] = p_ang;
    yaw_hist[WINDOW_LEN - 1] = yaw_filtered;
    est.pitch_angle = angle_t'(p_ang);
    est.pitch_rate = rate_t'(window_slope(pitch_hist));
    est.yaw_angle = angle_t'(yaw_filtered);
    est.yaw_rate = rate_t'(window_slope(yaw_hist));
    return est;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_count < 10)
      $display("t=%0t mismatch %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pending_estimates.push_back(predict_estimate(s_tdata[20:0], s_tdata[41:21],
                                                   s_tdata[65:42]));
  end

  // Compare every accepted output beat with the oldest prediction
  always @(posedge clk) begin
    estimate_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_estimates.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, m_tdata[31:0]);
      end else begin
        want = pending_estimates.pop_front();
        if (m_tdata[25:0] != want.pitch_angle)
          note_mismatch("pitch_angle", 32'(want.pitch_angle), 32'(m_tdata[25:0]));
        if (m_tdata[55:26] != want.pitch_rate)
          note_mismatch("pitch_rate", 32'(want.pitch_rate), 32'(m_tdata[55:26]));
        if (m_tdata[81:56] != want.yaw_angle)
          note_mismatch("yaw_angle", 32'(want.yaw_angle), 32'(m_tdata[81:56]));
        if (m_tdata[111:82] != want.yaw_rate)
          note_mismatch("yaw_rate", 32'(want.yaw_rate), 32'(m_tdata[111:82]));
      end
    end
  end

  // Stall the output side in random bursts; hold ready high once idling ends
  always @(negedge clk) begin
    if (!bursty) begin
      m_tready <= 1'b1;
      ready_burst_left <= 0;
    end else if (ready_burst_left != 0) begin
      ready_burst_left <= ready_burst_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      ready_burst_left <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
      ready_burst_left <= $urandom_range(0, 15);
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Present one sample and hold it until the beat is taken
  task automatic send_sample(input count_t pc, input count_t yc, input heading_t hd);
    @(negedge clk);
    if (bursty && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, hd, yc, pc};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait for every predicted beat to come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (addr[3:2])
      REG_PITCH_CENTER: cfg_pitch_center = data[CENTER_W-1:0];
      REG_YAW_CENTER:   cfg_yaw_center = data[CENTER_W-1:0];
      REG_HEADING_NEG:  cfg_heading_negate = data[0];
      default: ;
    endcase
  endtask

  task automatic apb_check_read(input logic [3:0] addr, input logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) note_mismatch("register readback", want, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all three registers, with junk in the unused upper bits
  task automatic configure(input center_t pc, input center_t yc, input logic neg);
    apb_write(ADDR_PITCH_CENTER, ($urandom & ~32'h1FFF) | 32'(pc));
    apb_write(ADDR_YAW_CENTER, ($urandom & ~32'h1FFF) | 32'(yc));
    apb_write(ADDR_HEADING_NEG, ($urandom & ~32'h1) | 32'(neg));
  endtask

  function automatic longint corner_value(input int w);
    case ($urandom_range(0, 3))
      0: return -(longint'(1) << (w - 1));
      1: return (longint'(1) << (w - 1)) - 1;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Reset values, masking of wide writes, and writes outside the map
  task automatic test_register_access();
    apb_check_read(ADDR_PITCH_CENTER, '0);
    apb_check_read(ADDR_YAW_CENTER, '0);
    apb_check_read(ADDR_HEADING_NEG, '0);
    apb_write(ADDR_PITCH_CENTER, '1);
    apb_write(ADDR_YAW_CENTER, '1);
    apb_write(ADDR_HEADING_NEG, '1);
    apb_write(ADDR_UNMAPPED, $urandom);
    apb_check_read(ADDR_PITCH_CENTER, 32'(CENTER_MAX));
    apb_check_read(ADDR_YAW_CENTER, 32'(CENTER_MAX));
    apb_check_read(ADDR_HEADING_NEG, 32'd1);
  endtask

  // Field limits with both centers and both heading signs
  task automatic test_field_extremes();
    configure('0, '0, 1'b0);
    send_sample(COUNT_MIN, COUNT_MIN, HEADING_MIN);
    send_sample(COUNT_MAX, COUNT_MAX, HEADING_MAX);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    wait_drained();
    configure(CENTER_MAX, CENTER_MAX, 1'b1);
    send_sample(COUNT_MIN, COUNT_MAX, HEADING_MIN);
    send_sample(COUNT_MAX, COUNT_MIN, HEADING_MAX);
    send_sample('0, '0, '1);
    wait_drained();
  endtask

  // Half window low then half high, and back, for the steepest slopes
  task automatic test_rate_extremes();
    configure('0, '0, 1'b0);
    repeat (HALF_LEN) send_sample(COUNT_MIN, COUNT_MIN, HEADING_MIN);
    repeat (HALF_LEN) send_sample(COUNT_MAX, COUNT_MAX, HEADING_MAX);
    repeat (HALF_LEN) send_sample(COUNT_MIN, COUNT_MIN, HEADING_MIN);
    wait_drained();
  endtask

  // Segments of noise, ramps, holds and corner values under one setting
  task automatic test_random_phase(input int items, input center_t pc, input center_t yc,
                                   input logic neg, input bit idling, input bit pause_midway);
    int            sent;
    int            seg_len;
    segment_kind_t kind;
    longint        p_base, y_base, h_base;
    longint        p_step, y_step, h_step;
    count_t        p_val, y_val;
    heading_t      h_val;
    wait_drained();
    configure(pc, yc, neg);
    bursty = idling;
    sent = 0;
    while (sent < items) begin
      seg_len = $urandom_range(8, 40);
      kind = segment_kind_t'($urandom_range(0, 3));
      p_base = longint'(count_t'($urandom));
      y_base = longint'(count_t'($urandom));
      h_base = longint'(heading_t'($urandom));
      p_step = longint'($urandom_range(0, 4000)) - 2000;
      y_step = longint'($urandom_range(0, 4000)) - 2000;
      h_step = longint'($urandom_range(0, 40000)) - 20000;
      for (int k = 0; k < seg_len && sent < items; k++) begin
        case (kind)
          SEG_NOISE: begin
            p_val = count_t'($urandom);
            y_val = count_t'($urandom);
            h_val = heading_t'($urandom);
          end
          SEG_RAMP: begin
            p_val = count_t'(p_base + p_step * k);
            y_val = count_t'(y_base + y_step * k);
            h_val = heading_t'(h_base + h_step * k);
          end
          SEG_HOLD: begin
            p_val = count_t'(p_base + $urandom_range(0, 4) - 2);
            y_val = count_t'(y_base + $urandom_range(0, 4) - 2);
            h_val = heading_t'(h_base + $urandom_range(0, 4) - 2);
          end
          default: begin
            p_val = count_t'(corner_value(COUNT_W));
            y_val = count_t'(corner_value(COUNT_W));
            h_val = heading_t'(corner_value(HEADING_W));
          end
        endcase
        send_sample(p_val, y_val, h_val);
        sent++;
        if (pause_midway && sent == items / 2) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_field_extremes();
    test_rate_extremes();
    test_random_phase(240, center_t'($urandom), center_t'($urandom), 1'($urandom), 1'b1, 1'b0);
    test_random_phase(240, CENTER_MAX, CENTER_MAX, 1'b1, 1'b1, 1'b1);
    test_random_phase(230, '0, '0, 1'b1, 1'b1, 1'b0);
    test_random_phase(240, center_t'($urandom), center_t'($urandom), 1'($urandom), 1'b0, 1'b0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_estimates.size() != 0) mismatch_count++;
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
